FILE: hw/rtl/vbap_pkg.sv
// shared widths, register indexes and helper functions of the stereo panner
package vbap_pkg;

    localparam int POS_W   = 16;
    localparam int COEF_W  = 16;
    localparam int RAMP_W  = 16;
    localparam int SMP_W   = 24;
    localparam int GAIN_W  = 32;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int DIVN_W  = 63;
    localparam int QUO_W   = 31;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_M11   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_M12   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_M21   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_M22   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 3'd4;

    localparam logic [COEF_W-1:0] RST_INV_DIAG = 16'd4096;
    localparam logic [COEF_W-1:0] RST_INV_OFF  = 16'd0;
    localparam logic [RAMP_W-1:0] RST_RAMP     = 16'd1024;

    localparam logic [QUO_W-1:0] Q30_ONE = 31'h4000_0000;

    // clamp a 50-bit two's complement value into 32 bits
    function automatic logic [GAIN_W-1:0] sat_to_32(input logic [49:0] v);
        logic [18:0] top;
        top = v[49:31];
        if ((&top) || (~|top)) begin
            return v[31:0];
        end else if (v[49]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    // clamp a 27-bit two's complement value into 24 bits
    function automatic logic [SMP_W-1:0] sat_to_24(input logic [26:0] v);
        logic [3:0] top;
        top = v[26:23];
        if ((&top) || (~|top)) begin
            return v[23:0];
        end else if (v[26]) begin
            return 24'h80_0000;
        end else begin
            return 24'h7F_FFFF;
        end
    endfunction

    function automatic logic fits_24(input logic [26:0] v);
        return (&v[26:23]) || (~|v[26:23]);
    endfunction

endpackage

FILE: hw/rtl/vbap_mul.sv
// shared signed multiplier with registered product
module vbap_mul import vbap_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: hw/rtl/vbap_isqrt.sv
// iterative floor square root, two radicand bits per cycle
module vbap_isqrt import vbap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_num;
    logic [ROOT_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [ROOT_W+1:0] w_trial_in;
    logic [ROOT_W+1:0] w_trial;
    logic [ROOT_W+1:0] w_diff;
    logic              w_take;

    // remainder stays below twice the partial root, so its top bits are free
    assign w_trial_in = {r_rem, r_num[RAD_W-1 -: 2]};
    assign w_trial    = {r_root, 2'b01};
    assign w_diff     = w_trial_in - w_trial;
    assign w_take     = (w_trial_in >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[RAD_W-3:0], 2'b00};
            if (w_take) begin
                r_rem  <= w_diff[ROOT_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial_in[ROOT_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hw/rtl/vbap_div.sv
// iterative restoring divider, one quotient bit per cycle
module vbap_div import vbap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVN_W-1:0] i_num,
    input  logic [ROOT_W-1:0] i_den,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [QUO_W-1:0]  r_num;
    logic [ROOT_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_den;
    logic [QUO_W-1:0]  r_quo;

    logic [ROOT_W:0]   w_part;
    logic [ROOT_W:0]   w_diff;
    logic              w_take;

    assign w_part = {r_rem, r_num[QUO_W-1]};
    assign w_diff = w_part - {1'b0, r_den};
    assign w_take = (w_part >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient fits in QUO_W bits, so the top part starts below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DIVN_W-1 -: ROOT_W];
            r_num <= i_num[QUO_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_take};
            r_rem <= w_take ? w_diff[ROOT_W-1:0] : w_part[ROOT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: hw/rtl/vbap_2d_stereo_panner_ramped.sv
// Two-speaker 2D amplitude panner with ramped gains. One item is worked on at a time
// and the input stalls meanwhile. A sample item steps the gains, multiplies each by the
// sample on the shared 33x33 multiplier and adds the mix inputs, then hands its result
// to the output register, waiting there while the output stalls. A position item
// returns no result and runs a matrix product, a normalizing shift (one bit a cycle),
// the squares, a bit-serial root, the two serial divides and the ramp steps; a zero
// direction goes from the shift straight to the ramp steps. Configuration writes are
// always taken and must only be issued while the block is idle.
module vbap_2d_stereo_panner_ramped import vbap_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [SMP_W-1:0]      i_sample_in,
    input  logic [SMP_W-1:0]      i_mix_in_left,
    input  logic [SMP_W-1:0]      i_mix_in_right,
    input  logic                  i_chunk_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SMP_W-1:0]      o_mix_out_left,
    output logic [SMP_W-1:0]      o_mix_out_right,
    output logic                  o_clipped,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COEF_W-1:0]     i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_GAIN = 9'b000000010,
        S_NORM = 9'b000000100,
        S_SQ   = 9'b000001000,
        S_ROOT = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_STEP = 9'b001000000,
        S_MIX  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;

    logic [COEF_W-1:0]  r_m11, r_m12, r_m21, r_m22;
    logic [RAMP_W-1:0]  r_ramp;

    logic [POS_W-1:0]   r_pos_x, r_pos_y;
    logic [SMP_W-1:0]   r_smp;
    logic [SMP_W-1:0]   r_mix_l, r_mix_r;
    logic               r_last;
    logic               r_clip;

    logic [RAD_W-1:0]   r_acc;
    logic [GAIN_W-1:0]  r_mag_l, r_mag_r;
    logic               r_neg_l, r_neg_r;
    logic [ROOT_W-1:0]  r_len;

    logic [GAIN_W-1:0]  r_goal_l, r_goal_r;
    logic [GAIN_W-1:0]  r_step_l, r_step_r;
    logic [GAIN_W-1:0]  r_now_l, r_now_r;

    logic               r_out_valid;
    logic [SMP_W-1:0]   r_out_l, r_out_r;
    logic               r_out_clip;

    logic               w_in_accept;
    logic               w_out_free;

    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]        w_prod_u;

    logic [GAIN_W:0]    w_gsum;
    logic [GAIN_W:0]    w_gneg;
    logic [GAIN_W-1:0]  w_gmag;

    logic               w_sqrt_start, w_sqrt_done;
    logic [RAD_W-1:0]   w_radicand;
    logic [ROOT_W-1:0]  w_root;

    logic               w_div_start, w_div_done;
    logic [GAIN_W-1:0]  w_div_mag;
    logic [DIVN_W-1:0]  w_div_num;
    logic [QUO_W-1:0]   w_quo;
    logic [QUO_W-1:0]   w_q_clamp;
    logic               w_div_neg;
    logic [GAIN_W-1:0]  w_goal;

    logic [GAIN_W:0]    w_diff_l, w_diff_r;
    logic [PROD_W-1:0]  w_step_rnd;
    logic [GAIN_W-1:0]  w_step;

    logic [GAIN_W:0]    w_now_sum_l, w_now_sum_r;
    logic [PROD_W-1:0]  w_mix_rnd;
    logic [SMP_W-1:0]   w_mix_src;
    logic [26:0]        w_mix_sum;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_prod_u = w_prod;

    // matrix row sum and its magnitude
    assign w_gsum = {r_acc[GAIN_W-1], r_acc[GAIN_W-1:0]}
                  + {w_prod_u[GAIN_W-1], w_prod_u[GAIN_W-1:0]};
    assign w_gneg = -w_gsum;
    assign w_gmag = w_gsum[GAIN_W] ? w_gneg[GAIN_W-1:0] : w_gsum[GAIN_W-1:0];

    assign w_radicand   = r_acc + w_prod_u[RAD_W-1:0];
    assign w_sqrt_start = (r_state == S_SQ) && (r_cnt == CNT_W'(2));

    // left lane on counts 0/1, right lane on counts 2/3
    assign w_div_mag   = r_cnt[1] ? r_mag_r : r_mag_l;
    assign w_div_neg   = r_cnt[1] ? r_neg_r : r_neg_l;
    assign w_div_num   = {1'b0, w_div_mag, 30'b0} + {32'b0, r_len[ROOT_W-1:1]};
    assign w_div_start = (r_state == S_DIV) && !r_cnt[0];
    assign w_q_clamp   = (w_quo > Q30_ONE) ? Q30_ONE : w_quo;
    assign w_goal      = w_div_neg ? -{1'b0, w_q_clamp} : {1'b0, w_q_clamp};

    assign w_diff_l   = {r_goal_l[GAIN_W-1], r_goal_l} - {r_now_l[GAIN_W-1], r_now_l};
    assign w_diff_r   = {r_goal_r[GAIN_W-1], r_goal_r} - {r_now_r[GAIN_W-1], r_now_r};
    assign w_step_rnd = w_prod_u + PROD_W'(1 << 15);
    assign w_step     = sat_to_32(w_step_rnd[65:16]);

    assign w_now_sum_l = {r_now_l[GAIN_W-1], r_now_l} + {r_step_l[GAIN_W-1], r_step_l};
    assign w_now_sum_r = {r_now_r[GAIN_W-1], r_now_r} + {r_step_r[GAIN_W-1], r_step_r};

    // gain * sample rounded by 2^30 lands within 26 bits
    assign w_mix_rnd = w_prod_u + PROD_W'(1 << 29);
    assign w_mix_src = (r_cnt == CNT_W'(2)) ? r_mix_l : r_mix_r;
    assign w_mix_sum = {{3{w_mix_src[SMP_W-1]}}, w_mix_src}
                     + {w_mix_rnd[55], w_mix_rnd[55:30]};

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_GAIN: begin
                w_mul_a = r_cnt[0] ? MUL_W'(signed'(r_pos_y)) : MUL_W'(signed'(r_pos_x));
                case (r_cnt[1:0])
                    2'd0:    w_mul_b = MUL_W'(signed'(r_m11));
                    2'd1:    w_mul_b = MUL_W'(signed'(r_m21));
                    2'd2:    w_mul_b = MUL_W'(signed'(r_m12));
                    default: w_mul_b = MUL_W'(signed'(r_m22));
                endcase
            end
            S_SQ: begin
                w_mul_a = r_cnt[0] ? {1'b0, r_mag_r} : {1'b0, r_mag_l};
                w_mul_b = w_mul_a;
            end
            S_STEP: begin
                w_mul_a = r_cnt[0] ? w_diff_r : w_diff_l;
                w_mul_b = {17'b0, r_ramp};
            end
            S_MIX: begin
                w_mul_a = (r_cnt == CNT_W'(1)) ? {r_now_l[GAIN_W-1], r_now_l}
                                               : {r_now_r[GAIN_W-1], r_now_r};
                w_mul_b = MUL_W'(signed'(r_smp));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    vbap_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    vbap_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_radicand),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    vbap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_len),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m11  <= RST_INV_DIAG;
            r_m12  <= RST_INV_OFF;
            r_m21  <= RST_INV_OFF;
            r_m22  <= RST_INV_DIAG;
            r_ramp <= RST_RAMP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INV_M11:   r_m11  <= i_cfg_data;
                CFG_INV_M12:   r_m12  <= i_cfg_data;
                CFG_INV_M21:   r_m21  <= i_cfg_data;
                CFG_INV_M22:   r_m22  <= i_cfg_data;
                CFG_RAMP_STEP: r_ramp <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // item payload and working registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_smp   <= i_sample_in;
            r_mix_l <= i_mix_in_left;
            r_mix_r <= i_mix_in_right;
            r_last  <= i_chunk_last;
        end
        case (r_state)
            S_GAIN: begin
                if (r_cnt[0]) begin
                    r_acc <= w_prod_u[RAD_W-1:0];
                end
                if (r_cnt == CNT_W'(2)) begin
                    r_mag_l <= w_gmag;
                    r_neg_l <= w_gsum[GAIN_W];
                end
                if (r_cnt == CNT_W'(4)) begin
                    r_mag_r <= w_gmag;
                    r_neg_r <= w_gsum[GAIN_W];
                end
            end
            S_NORM: begin
                if ((r_mag_l[31:29] == 3'b000) && (r_mag_r[31:29] == 3'b000)) begin
                    r_mag_l <= {r_mag_l[GAIN_W-2:0], 1'b0};
                    r_mag_r <= {r_mag_r[GAIN_W-2:0], 1'b0};
                end
            end
            S_SQ: begin
                if (r_cnt == CNT_W'(1)) begin
                    r_acc <= w_prod_u[RAD_W-1:0];
                end
            end
            S_ROOT: begin
                if (w_sqrt_done) begin
                    r_len <= w_root;
                end
            end
            S_MIX: begin
                if (r_cnt == CNT_W'(2)) begin
                    r_mix_l <= sat_to_24(w_mix_sum);
                end
                if (r_cnt == CNT_W'(3)) begin
                    r_mix_r <= sat_to_24(w_mix_sum);
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer and gain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_clip   <= 1'b0;
            r_goal_l <= '0;
            r_goal_r <= '0;
            r_step_l <= '0;
            r_step_r <= '0;
            r_now_l  <= '0;
            r_now_r  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt  <= '0;
                    r_clip <= 1'b0;
                    if (w_in_accept) begin
                        r_state <= i_cmd ? S_MIX : S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(4)) begin
                        r_cnt   <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if ((r_mag_l == '0) && (r_mag_r == '0)) begin
                        // zero direction gives zero goals
                        r_goal_l <= '0;
                        r_goal_r <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_STEP;
                    end else if (!((r_mag_l[31:29] == 3'b000) &&
                                   (r_mag_r[31:29] == 3'b000))) begin
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(2)) begin
                        r_cnt   <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_sqrt_done) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!r_cnt[0]) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (w_div_done) begin
                        if (r_cnt[1]) begin
                            r_goal_r <= w_goal;
                            r_cnt    <= '0;
                            r_state  <= S_STEP;
                        end else begin
                            r_goal_l <= w_goal;
                            r_cnt    <= r_cnt + 1'b1;
                        end
                    end
                end
                S_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_step_l <= w_step;
                    end
                    if (r_cnt == CNT_W'(2)) begin
                        r_step_r <= w_step;
                        r_cnt    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                S_MIX: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(0)) begin
                        r_now_l <= sat_to_32({{17{w_now_sum_l[GAIN_W]}}, w_now_sum_l});
                        r_now_r <= sat_to_32({{17{w_now_sum_r[GAIN_W]}}, w_now_sum_r});
                    end
                    if ((r_cnt == CNT_W'(2)) || (r_cnt == CNT_W'(3))) begin
                        if (!fits_24(w_mix_sum)) begin
                            r_clip <= 1'b1;
                        end
                    end
                    if (r_cnt == CNT_W'(3)) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        if (r_last) begin
                            // chunk end: land exactly on the goal
                            r_now_l  <= r_goal_l;
                            r_now_r  <= r_goal_r;
                            r_step_l <= '0;
                            r_step_r <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_cnt   <= '0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_l    <= r_mix_l;
            r_out_r    <= r_mix_r;
            r_out_clip <= r_clip;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mix_out_left  = r_out_l;
    assign o_mix_out_right = r_out_r;
    assign o_clipped       = r_out_clip;

endmodule
